/* src/dlf_pkg.sv */
// ----------------------------------------------------------------------------
// dlf_pkg: shared types and codes for the dense layer forward core
// Field widths, input item modes, register indexes, command kinds and queue
// depths that the front, back and top level all see.
// ----------------------------------------------------------------------------
package dlf_pkg;

  localparam int unsigned IDX_W     = 6;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // input item modes
  localparam logic [MODE_W-1:0] MODE_WEIGHT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BIAS    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FEATURE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE  = 2'd2;

  localparam logic [CNT_W-1:0] INPUT_COUNT_RST  = 7'd64;
  localparam logic [CNT_W-1:0] OUTPUT_COUNT_RST = 7'd64;
  localparam logic             BIAS_ENABLE_RST  = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned OUT_DEPTH   = 4;
  localparam int unsigned OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_WEIGHT,
    KIND_BIAS,
    KIND_FEATURE
  } kind_e;

  typedef struct packed {
    logic [CNT_W-1:0] input_count;
    logic [CNT_W-1:0] output_count;
    logic             bias_enable;
  } cfg_t;

endpackage

/* src/dlf_ram.sv */
// ----------------------------------------------------------------------------
// dlf_ram: generic single write port RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module dlf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/dlf_fifo.sv */
// ----------------------------------------------------------------------------
// dlf_fifo: small register FIFO
// Used for the command queue between front and back and for the result queue.
// ----------------------------------------------------------------------------
module dlf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o,
  output logic [CW-1:0]    count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             push_ok, pop_ok;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    count_d = count_q + CW'(push_ok) - CW'(pop_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

/* src/dlf_front.sv */
// ----------------------------------------------------------------------------
// dlf_front: input side of the dense layer core
// Takes input beats, drops unused modes and out of range writes, turns the
// rest into commands with a flat store address and hands them to the queue.
// ----------------------------------------------------------------------------
module dlf_front #(
  parameter int unsigned MAX_INPUTS  = 64,
  parameter int unsigned MAX_OUTPUTS = 64,
  parameter int unsigned DATA_WIDTH  = 16,
  localparam int unsigned WAW = (MAX_OUTPUTS * MAX_INPUTS > 1) ?
                                $clog2(MAX_OUTPUTS * MAX_INPUTS) : 1
) (
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dlf_pkg::MODE_W-1:0]   mode_i,
  input  logic [dlf_pkg::IDX_W-1:0]    out_index_i,
  input  logic [dlf_pkg::IDX_W-1:0]    in_index_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output dlf_pkg::kind_e               kind_o,
  output logic [WAW-1:0]               addr_o,
  output logic [DATA_WIDTH-1:0]        value_o
);
  import dlf_pkg::*;

  logic take;
  logic oi_ok, ii_ok;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && !q_full_i;
  assign oi_ok      = (32'(out_index_i) < MAX_OUTPUTS);
  assign ii_ok      = (32'(in_index_i) < MAX_INPUTS);
  assign value_o    = value_i;

  always_comb begin
    push_o = 1'b0;
    kind_o = KIND_FEATURE;
    addr_o = '0;
    case (mode_i)
      MODE_WEIGHT: begin
        kind_o = KIND_WEIGHT;
        addr_o = WAW'(32'(out_index_i) * MAX_INPUTS + 32'(in_index_i));
        push_o = take && oi_ok && ii_ok;
      end
      MODE_BIAS: begin
        kind_o = KIND_BIAS;
        addr_o = WAW'(out_index_i);
        push_o = take && oi_ok;
      end
      MODE_FEATURE: begin
        push_o = take;
      end
      default: begin
        // unused mode is swallowed
        push_o = 1'b0;
      end
    endcase
  end

endmodule

/* src/dlf_back.sv */
// ----------------------------------------------------------------------------
// dlf_back: execution side of the dense layer core
// Applies store writes, runs one shared multiply-accumulate over all output
// neurons for each feature and, at the end of a row, reads out output_count
// accumulators, adds bias if enabled, rounds, saturates and queues them.
// ----------------------------------------------------------------------------
module dlf_back #(
  parameter int unsigned MAX_INPUTS  = 64,
  parameter int unsigned MAX_OUTPUTS = 64,
  parameter int unsigned DATA_WIDTH  = 16,
  parameter int unsigned FRAC_BITS   = 12,
  parameter int unsigned ACC_WIDTH   = 48,
  localparam int unsigned WAW = (MAX_OUTPUTS * MAX_INPUTS > 1) ?
                                $clog2(MAX_OUTPUTS * MAX_INPUTS) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dlf_pkg::cfg_t                   cfg_i,
  input  logic                            cmd_valid_i,
  input  dlf_pkg::kind_e                  cmd_kind_i,
  input  logic [WAW-1:0]                  cmd_addr_i,
  input  logic [DATA_WIDTH-1:0]           cmd_value_i,
  output logic                            cmd_pop_o,
  input  logic [dlf_pkg::OUT_CNT_W-1:0]   out_count_i,
  output logic                            res_push_o,
  output logic [dlf_pkg::IDX_W-1:0]       res_index_o,
  output logic [DATA_WIDTH-1:0]           res_value_o,
  output logic                            res_last_o
);
  import dlf_pkg::*;

  localparam int unsigned OAW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int unsigned PAW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int unsigned NINW = $clog2(MAX_INPUTS + 1);
  localparam int unsigned NOUTW = $clog2(MAX_OUTPUTS + 1);
  localparam int unsigned QW   = (ACC_WIDTH > DATA_WIDTH) ? ACC_WIDTH + 1 : DATA_WIDTH + 1;
  localparam int unsigned RB   = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]     state_q, state_d;
  logic [OAW-1:0] j_q, j_d;
  logic [WAW-1:0] waddr_q, waddr_d;
  logic [PAW-1:0] pos_q, pos_d;

  logic signed [DATA_WIDTH-1:0] x_q;
  logic                         zero_q;

  // multiply-accumulate pipeline
  logic                           v1_q, v2_q;
  logic [OAW-1:0]                 j1_q, j2_q;
  logic signed [2*DATA_WIDTH-1:0] prod_q;
  logic [ACC_WIDTH-1:0]           accin_q;

  // readout pipeline
  logic                        e1_q, e2_q;
  logic [OAW-1:0]              ej1_q, ej2_q;
  logic                        elast1_q, elast2_q;
  logic signed [ACC_WIDTH-1:0] t_q;

  logic [NINW-1:0]  nin;
  logic [NOUTW-1:0] nout;

  logic pop, issue_mac, issue_emit, credit_ok;
  logic j_last_mac, j_last_emit, pos_end;

  logic [DATA_WIDTH-1:0] w_rdata, b_rdata;
  logic [ACC_WIDTH-1:0]  acc_rdata;
  logic [ACC_WIDTH-1:0]  acc_wdata;

  logic signed [DATA_WIDTH-1:0] w_s, b_s;
  logic signed [ACC_WIDTH-1:0]  bias_ext, bias_add;
  logic signed [QW-1:0]         fl, q_w;
  logic                         rbit, fits;

  // counts out of range are used clamped
  always_comb begin
    if (cfg_i.input_count == '0) begin
      nin = NINW'(1);
    end else if (32'(cfg_i.input_count) > MAX_INPUTS) begin
      nin = NINW'(MAX_INPUTS);
    end else begin
      nin = NINW'(cfg_i.input_count);
    end
    if (cfg_i.output_count == '0) begin
      nout = NOUTW'(1);
    end else if (32'(cfg_i.output_count) > MAX_OUTPUTS) begin
      nout = NOUTW'(MAX_OUTPUTS);
    end else begin
      nout = NOUTW'(cfg_i.output_count);
    end
  end

  assign pop         = (state_q == S_IDLE) && cmd_valid_i;
  assign cmd_pop_o   = pop;
  assign issue_mac   = (state_q == S_MAC);
  assign credit_ok   = (32'(out_count_i) + 32'(e1_q) + 32'(e2_q)) < OUT_DEPTH;
  assign issue_emit  = (state_q == S_EMIT) && credit_ok;
  assign j_last_mac  = (j_q == OAW'(MAX_OUTPUTS - 1));
  assign j_last_emit = ((32'(j_q) + 32'd1) == 32'(nout));
  assign pos_end     = ((32'(pos_q) + 32'd1) >= 32'(nin));

  always_comb begin
    state_d = state_q;
    j_d     = j_q;
    waddr_d = waddr_q;
    pos_d   = pos_q;
    case (state_q)
      S_IDLE: begin
        if (pop && cmd_kind_i == KIND_FEATURE) begin
          state_d = S_MAC;
          j_d     = '0;
          waddr_d = WAW'(pos_q);
        end
      end
      S_MAC: begin
        j_d     = j_q + OAW'(1);
        waddr_d = waddr_q + WAW'(MAX_INPUTS);
        if (j_last_mac) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v1_q && !v2_q) begin
          if (pos_end) begin
            pos_d   = '0;
            j_d     = '0;
            state_d = S_EMIT;
          end else begin
            pos_d   = pos_q + PAW'(1);
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (issue_emit) begin
          j_d = j_q + OAW'(1);
          if (j_last_emit) begin
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!e1_q && !e2_q) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      j_q     <= '0;
      waddr_q <= '0;
      pos_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      e1_q    <= 1'b0;
      e2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      waddr_q <= waddr_d;
      pos_q   <= pos_d;
      v1_q    <= issue_mac;
      v2_q    <= v1_q;
      e1_q    <= issue_emit;
      e2_q    <= e1_q;
    end
  end

  // stores
  dlf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_OUTPUTS * MAX_INPUTS)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (pop && cmd_kind_i == KIND_WEIGHT),
    .waddr_i (cmd_addr_i),
    .wdata_i (cmd_value_i),
    .raddr_i (waddr_q),
    .rdata_o (w_rdata)
  );

  dlf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_OUTPUTS)
  ) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (pop && cmd_kind_i == KIND_BIAS),
    .waddr_i (cmd_addr_i[OAW-1:0]),
    .wdata_i (cmd_value_i),
    .raddr_i (j_q),
    .rdata_o (b_rdata)
  );

  assign acc_wdata = accin_q + ACC_WIDTH'(prod_q);

  dlf_ram #(
    .WIDTH (ACC_WIDTH),
    .DEPTH (MAX_OUTPUTS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (v2_q),
    .waddr_i (j2_q),
    .wdata_i (acc_wdata),
    .raddr_i (j_q),
    .rdata_o (acc_rdata)
  );

  assign w_s      = signed'(w_rdata);
  assign b_s      = signed'(b_rdata);
  assign bias_ext = ACC_WIDTH'(b_s);
  assign bias_add = cfg_i.bias_enable ? (bias_ext <<< FRAC_BITS) : '0;

  // first feature of a row starts from zero instead of the stale accumulator
  always_ff @(posedge clk_i) begin
    if (pop && cmd_kind_i == KIND_FEATURE) begin
      x_q    <= signed'(cmd_value_i);
      zero_q <= (pos_q == '0);
    end
    j1_q     <= j_q;
    j2_q     <= j1_q;
    prod_q   <= x_q * w_s;
    accin_q  <= zero_q ? '0 : acc_rdata;
    ej1_q    <= j_q;
    elast1_q <= j_last_emit;
    ej2_q    <= ej1_q;
    elast2_q <= elast1_q;
    t_q      <= signed'(acc_rdata) + bias_add;
  end

  // round half up, then saturate to the data range
  always_comb begin
    rbit = (FRAC_BITS > 0) ? t_q[RB] : 1'b0;
    fl   = QW'(t_q >>> FRAC_BITS);
    q_w  = fl + QW'(rbit);
    fits = (q_w[QW-1:DATA_WIDTH-1] == {(QW - DATA_WIDTH + 1){q_w[QW-1]}});
    if (fits) begin
      res_value_o = q_w[DATA_WIDTH-1:0];
    end else if (q_w[QW-1]) begin
      res_value_o = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
    end else begin
      res_value_o = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    end
  end

  assign res_push_o  = e2_q;
  assign res_index_o = IDX_W'(ej2_q);
  assign res_last_o  = elast2_q;

endmodule

/* src/dense_layer_forward_core.sv */
// ----------------------------------------------------------------------------
// dense_layer_forward_core: fixed point fully connected layer, forward pass
// Weight and bias writes and sample features enter on one channel; at the
// end of each row the rounded, saturated outputs leave in neuron order.
//
//   channel  direction  handshake              payload
//   input    in         in_valid_i/in_ready_o   mode_i out_index_i in_index_i value_i
//   output   out        out_valid_o/out_ready_i out_index_res_o result_o last_o
//   config   in         cfg_valid_i/cfg_ready_o cfg_index_i cfg_data_i
//
// A weight or bias write goes into its store when the back end pops it. For a
// feature the shared multiply-accumulate visits every neuron once, one weight
// and accumulator read per cycle, then drains its pipeline. A row end then
// streams output_count results at up to one per cycle while the result queue
// has room, through a read, bias, round path into a four entry result queue.
// No clearing pass after reset: a row's first feature overwrites the
// accumulators. A 4-entry command queue lets input beats land while busy.
// ----------------------------------------------------------------------------
module dense_layer_forward_core #(
  parameter int unsigned MAX_INPUTS  = 64,
  parameter int unsigned MAX_OUTPUTS = 64,
  parameter int unsigned DATA_WIDTH  = 16,
  parameter int unsigned FRAC_BITS   = 12,
  parameter int unsigned ACC_WIDTH   = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [dlf_pkg::MODE_W-1:0]     mode_i,
  input  logic [dlf_pkg::IDX_W-1:0]      out_index_i,
  input  logic [dlf_pkg::IDX_W-1:0]      in_index_i,
  input  logic signed [DATA_WIDTH-1:0]   value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dlf_pkg::IDX_W-1:0]      out_index_res_o,
  output logic signed [DATA_WIDTH-1:0]   result_o,
  output logic                           last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dlf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dlf_pkg::CNT_W-1:0]      cfg_data_i
);
  import dlf_pkg::*;

  localparam int unsigned WAW = (MAX_OUTPUTS * MAX_INPUTS > 1) ?
                                $clog2(MAX_OUTPUTS * MAX_INPUTS) : 1;
  localparam int unsigned QDW = 2 + WAW + DATA_WIDTH;
  localparam int unsigned ODW = IDX_W + DATA_WIDTH + 1;

  cfg_t cfg_q, cfg_d;

  logic                  f_push;
  kind_e                 f_kind;
  logic [WAW-1:0]        f_addr;
  logic [DATA_WIDTH-1:0] f_value;

  logic [QDW-1:0] q_wdata, q_rdata;
  logic           q_full, q_empty, q_pop;

  logic                  r_push, r_last;
  logic [IDX_W-1:0]      r_index;
  logic [DATA_WIDTH-1:0] r_value;
  logic [ODW-1:0]        o_wdata, o_rdata;
  logic                  o_empty;
  logic [OUT_CNT_W-1:0]  o_count;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_INPUT_COUNT:  cfg_d.input_count  = cfg_data_i;
        REG_OUTPUT_COUNT: cfg_d.output_count = cfg_data_i;
        REG_BIAS_ENABLE:  cfg_d.bias_enable  = cfg_data_i[0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.input_count  <= INPUT_COUNT_RST;
      cfg_q.output_count <= OUTPUT_COUNT_RST;
      cfg_q.bias_enable  <= BIAS_ENABLE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dlf_front #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_index_i (out_index_i),
    .in_index_i  (in_index_i),
    .value_i     (value_i),
    .q_full_i    (q_full),
    .push_o      (f_push),
    .kind_o      (f_kind),
    .addr_o      (f_addr),
    .value_o     (f_value)
  );

  assign q_wdata = {f_kind, f_addr, f_value};

  dlf_fifo #(
    .WIDTH (QDW),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty),
    .count_o ()
  );

  dlf_back #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .DATA_WIDTH  (DATA_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (!q_empty),
    .cmd_kind_i  (kind_e'(q_rdata[QDW-1 -: 2])),
    .cmd_addr_i  (q_rdata[DATA_WIDTH +: WAW]),
    .cmd_value_i (q_rdata[DATA_WIDTH-1:0]),
    .cmd_pop_o   (q_pop),
    .out_count_i (o_count),
    .res_push_o  (r_push),
    .res_index_o (r_index),
    .res_value_o (r_value),
    .res_last_o  (r_last)
  );

  assign o_wdata = {r_index, r_value, r_last};

  dlf_fifo #(
    .WIDTH (ODW),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (r_push),
    .data_i  (o_wdata),
    .pop_i   (out_ready_i),
    .data_o  (o_rdata),
    .full_o  (),
    .empty_o (o_empty),
    .count_o (o_count)
  );

  assign out_valid_o     = !o_empty;
  assign out_index_res_o = o_rdata[ODW-1 -: IDX_W];
  assign result_o        = signed'(o_rdata[DATA_WIDTH:1]);
  assign last_o          = o_rdata[0];

endmodule
